[rtl/gpe_pkg.sv]
// shared types and constants for the gga position extractor
// no dependencies; imported by the parser, the scaler and the top level
`default_nettype none

package gpe_pkg;

    localparam int unsigned VALUE_W = 34;

    // largest value a converted field may take
    localparam logic [VALUE_W-1:0] SAT_MAX = 34'd9999999999;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [2:0]         scale_t;

    // raw field values and the number of decimal places still owed to each
    typedef struct packed {
        value_t lat_raw;
        scale_t lat_scale;
        value_t lon_raw;
        scale_t lon_scale;
    } fix_t;

endpackage

`default_nettype wire

[rtl/gga_position_extractor.sv]
// the comma ending longitude loads the parser result stage, which feeds the output register
// throughput: one byte beat per cycle while rx_stall is low; the parser state register updates
// once per beat and the output register frees the parser result stage each cycle it is not stalled
// reset: asynchronous, active low; parser returns to hunting for a dollar sign, no result held
// top level: parser followed by the scaling stage and output register
// depends on gpe_pkg, gpe_parser, gpe_scaler
`default_nettype none

module gga_position_extractor #(
    parameter int FRAC_DIGITS = 5,
    parameter int FIELD_CHARS = 15
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rx_valid,
    output logic               rx_stall,
    input  wire logic [7:0]    rx_byte,
    output logic               pos_valid,
    input  wire logic          pos_stall,
    output gpe_pkg::value_t    latitude_fixed,
    output gpe_pkg::value_t    longitude_fixed
);
    import gpe_pkg::*;

    logic res_valid;
    logic res_ready;
    fix_t res;

    gpe_parser #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    gpe_scaler u_scaler (
        .clk             (clk),
        .rst_n           (rst_n),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .pos_valid       (pos_valid),
        .pos_stall       (pos_stall),
        .latitude_fixed  (latitude_fixed),
        .longitude_fixed (longitude_fixed)
    );

endmodule

`default_nettype wire

[rtl/gpe_parser.sv]
// sentence parser: header check, field walk and per-character digit accumulation
// depends on gpe_pkg; hands one fix_t per sentence to the scaler
`default_nettype none

module gpe_parser #(
    parameter int FRAC_DIGITS = 5,
    parameter int FIELD_CHARS = 15
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rx_valid,
    output logic              rx_stall,
    input  wire logic [7:0]   rx_byte,
    output logic              res_valid,
    input  wire logic         res_ready,
    output gpe_pkg::fix_t     res
);
    import gpe_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_TIME,
        PH_LAT,
        PH_NS,
        PH_LON
    } phase_t;

    localparam scale_t     FRAC_MAX  = scale_t'(FRAC_DIGITS);
    localparam logic [3:0] CHARS_MAX = 4'(FIELD_CHARS);

    phase_t     phase_reg, phase_next;
    logic [2:0] hdr_pos_reg, hdr_pos_next;
    logic       hdr_match_reg, hdr_match_next;
    value_t     lat_reg, lat_next;
    value_t     lon_reg, lon_next;
    scale_t     lat_scale_reg, lat_scale_next;
    logic [3:0] cnt_reg, cnt_next;
    scale_t     frac_reg, frac_next;
    logic       point_reg, point_next;
    logic       stop_reg, stop_next;
    logic       res_valid_reg, res_valid_next;
    fix_t       res_reg, res_next;

    logic       accept;
    logic       is_digit;
    logic [7:0] tag_char;
    value_t     cur_acc;
    logic [37:0] mac_wide;
    value_t     mac_val;

    // one field character step
    value_t     step_acc;
    logic [3:0] step_cnt;
    scale_t     step_frac;
    logic       step_point;
    logic       step_stop;

    assign rx_stall  = res_valid_reg && !res_ready;
    assign accept    = rx_valid && !rx_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign cur_acc  = (phase_reg == PH_LAT) ? lat_reg : lon_reg;

    // acc * 10 + digit, saturated
    assign mac_wide = (38'(cur_acc) << 3) + (38'(cur_acc) << 1) + 38'(rx_byte[3:0]);
    assign mac_val  = (mac_wide > 38'(SAT_MAX)) ? SAT_MAX : mac_wide[VALUE_W-1:0];

    always_comb
    begin
        unique case (hdr_pos_reg)
            3'd0:    tag_char = CH_G;
            3'd1:    tag_char = CH_P;
            3'd2:    tag_char = CH_G;
            3'd3:    tag_char = CH_G;
            3'd4:    tag_char = CH_A;
            default: tag_char = rx_byte;
        endcase
    end

    always_comb
    begin
        step_acc   = cur_acc;
        step_cnt   = cnt_reg;
        step_frac  = frac_reg;
        step_point = point_reg;
        step_stop  = stop_reg;
        if (cnt_reg < CHARS_MAX)
        begin
            step_cnt = cnt_reg + 4'd1;
            if (!stop_reg)
            begin
                if (is_digit)
                begin
                    if (!point_reg)
                    begin
                        step_acc = mac_val;
                    end
                    else if (frac_reg < FRAC_MAX)
                    begin
                        step_acc  = mac_val;
                        step_frac = frac_reg + scale_t'(1);
                    end
                end
                else if (rx_byte == CH_POINT && !point_reg)
                begin
                    step_point = 1'b1;
                end
                else
                begin
                    step_stop = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        hdr_match_next = hdr_match_reg;
        lat_next       = lat_reg;
        lon_next       = lon_reg;
        lat_scale_next = lat_scale_reg;
        cnt_next       = cnt_reg;
        frac_next      = frac_reg;
        point_next     = point_reg;
        stop_next      = stop_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;

        if (accept)
        begin
            if (rx_byte == CH_DOLLAR)
            begin
                phase_next     = PH_HEADER;
                hdr_pos_next   = 3'd0;
                hdr_match_next = 1'b1;
                lat_next       = '0;
                lon_next       = '0;
                cnt_next       = '0;
                frac_next      = '0;
                point_next     = 1'b0;
                stop_next      = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (hdr_pos_reg == 3'd5)
                        begin
                            hdr_pos_next   = 3'd0;
                            hdr_match_next = 1'b1;
                            phase_next     = hdr_match_reg ? PH_TIME : PH_HUNT;
                        end
                        else
                        begin
                            hdr_pos_next = hdr_pos_reg + 3'd1;
                            if (rx_byte != tag_char)
                            begin
                                hdr_match_next = 1'b0;
                            end
                        end
                    end
                    PH_TIME:
                    begin
                        if (rx_byte == CH_COMMA)
                        begin
                            lat_next   = '0;
                            cnt_next   = '0;
                            frac_next  = '0;
                            point_next = 1'b0;
                            stop_next  = 1'b0;
                            phase_next = PH_LAT;
                        end
                    end
                    PH_LAT:
                    begin
                        if (rx_byte == CH_COMMA)
                        begin
                            lat_scale_next = FRAC_MAX - frac_reg;
                            cnt_next       = '0;
                            frac_next      = '0;
                            point_next     = 1'b0;
                            stop_next      = 1'b0;
                            phase_next     = PH_NS;
                        end
                        else
                        begin
                            lat_next   = step_acc;
                            cnt_next   = step_cnt;
                            frac_next  = step_frac;
                            point_next = step_point;
                            stop_next  = step_stop;
                        end
                    end
                    PH_NS:
                    begin
                        if (rx_byte == CH_COMMA)
                        begin
                            lon_next   = '0;
                            cnt_next   = '0;
                            frac_next  = '0;
                            point_next = 1'b0;
                            stop_next  = 1'b0;
                            phase_next = PH_LON;
                        end
                    end
                    PH_LON:
                    begin
                        if (rx_byte == CH_COMMA)
                        begin
                            res_valid_next     = 1'b1;
                            res_next.lat_raw   = lat_reg;
                            res_next.lat_scale = lat_scale_reg;
                            res_next.lon_raw   = lon_reg;
                            res_next.lon_scale = FRAC_MAX - frac_reg;
                            cnt_next           = '0;
                            frac_next          = '0;
                            point_next         = 1'b0;
                            stop_next          = 1'b0;
                            phase_next         = PH_HUNT;
                        end
                        else
                        begin
                            lon_next   = step_acc;
                            cnt_next   = step_cnt;
                            frac_next  = step_frac;
                            point_next = step_point;
                            stop_next  = step_stop;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            hdr_pos_reg   <= 3'd0;
            hdr_match_reg <= 1'b1;
            lat_reg       <= '0;
            lon_reg       <= '0;
            lat_scale_reg <= '0;
            cnt_reg       <= '0;
            frac_reg      <= '0;
            point_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            hdr_match_reg <= hdr_match_next;
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            lat_scale_reg <= lat_scale_next;
            cnt_reg       <= cnt_next;
            frac_reg      <= frac_next;
            point_reg     <= point_next;
            stop_reg      <= stop_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

`ifndef ASSERT_OFF
    a_hdr_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEADER |-> hdr_pos_reg == 3'd0)
        else $error("header position left set outside header");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg <= FRAC_MAX && cnt_reg <= CHARS_MAX)
        else $error("field counters past their limits");

    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(accept && phase_reg == PH_LON && rx_byte == CH_COMMA))
        else $error("result raised without a closing comma");

    a_res_scale: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.lat_scale <= FRAC_MAX && res_reg.lon_scale <= FRAC_MAX)
        else $error("scale beyond fraction digits");
`endif

endmodule

`default_nettype wire

[rtl/gpe_scaler.sv]
// final scaling: multiplies each raw field by the missing power of ten, saturating
// depends on gpe_pkg; takes fix_t from the parser and holds the output register
`default_nettype none

module gpe_scaler (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    output logic               res_ready,
    input  wire gpe_pkg::fix_t res,
    output logic               pos_valid,
    input  wire logic          pos_stall,
    output gpe_pkg::value_t    latitude_fixed,
    output gpe_pkg::value_t    longitude_fixed
);
    import gpe_pkg::*;

    localparam value_t POW10 [8] = '{
        34'd1, 34'd10, 34'd100, 34'd1000,
        34'd10000, 34'd100000, 34'd1000000, 34'd10000000
    };

    // largest raw value whose scaled form still fits below saturation
    localparam value_t LIMIT [8] = '{
        34'd9999999999, 34'd999999999, 34'd99999999, 34'd9999999,
        34'd999999, 34'd99999, 34'd9999, 34'd999
    };

    logic   valid_reg, valid_next;
    value_t lat_reg, lat_next;
    value_t lon_reg, lon_next;
    value_t lat_scaled;
    value_t lon_scaled;

    // product only needs 34 bits when the raw value is within the limit
    assign lat_scaled = (res.lat_raw > LIMIT[res.lat_scale]) ? SAT_MAX
                        : value_t'(res.lat_raw * POW10[res.lat_scale]);
    assign lon_scaled = (res.lon_raw > LIMIT[res.lon_scale]) ? SAT_MAX
                        : value_t'(res.lon_raw * POW10[res.lon_scale]);

    assign res_ready       = !valid_reg || !pos_stall;
    assign pos_valid       = valid_reg;
    assign latitude_fixed  = lat_reg;
    assign longitude_fixed = lon_reg;

    always_comb
    begin
        valid_next = valid_reg && pos_stall;
        lat_next   = lat_reg;
        lon_next   = lon_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
            lat_next   = lat_scaled;
            lon_next   = lon_scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_reg <= lat_next;
        lon_reg <= lon_next;
    end

`ifndef ASSERT_OFF
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> lat_reg <= SAT_MAX && lon_reg <= SAT_MAX)
        else $error("output beyond saturation limit");

    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> valid_reg)
        else $error("taken beat did not reach the output register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && pos_stall |-> !res_ready)
        else $error("upstream taken while output is stalled");
`endif

endmodule

`default_nettype wire
